@@ sv/bpa_pkg.sv @@
// Shared constants, types and command codes of the buddy page allocator.
// Used by bpa_ctrl, bpa_dpath and buddy_page_allocator; depends on nothing.
package bpa_pkg;

	localparam int MAX_ORDER  = 10;
	localparam int NPAGES     = 1 << MAX_ORDER;
	localparam int PAGE_W     = MAX_ORDER;
	localparam int LINK_W     = PAGE_W + 1;
	localparam int LVL_W      = $clog2(MAX_ORDER + 2);
	localparam int HEAD_IDX_W = (MAX_ORDER < 1) ? 1 : $clog2(MAX_ORDER + 1);
	localparam int STEP_W     = PAGE_W + 1;
	localparam int ORDER_W    = 5;
	localparam int PAGE_IN_W  = 10;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(NPAGES);

	typedef enum logic [1:0] {
		RES_OK         = 2'd0,
		RES_ORDER_BIG  = 2'd1,
		RES_NO_BLOCK   = 2'd2,
		RES_DOUBLE_FREE = 2'd3
	} res_code_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCEPT,
		OP_LVL_INC,
		OP_POP_RD,
		OP_POP_WR,
		OP_POP_TAKE,
		OP_SPLIT_POP,
		OP_PUSH_BUD,
		OP_PUSH_BLK,
		OP_META_RD,
		OP_FREE_SET,
		OP_BUD_RD,
		OP_BUD_EVAL,
		OP_RM_START,
		OP_RM_STEP,
		OP_RM_UNLINK,
		OP_RM_LINK,
		OP_RM_NEXT,
		OP_FINISH,
		OP_OUT_LOAD
	} op_t;

	typedef struct packed {
		op_t       op;
		res_code_t code;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic ord_big;
		logic lvl_gt_max;
		logic head_nil;
		logic lvl_eq_ord;
		logic lvl_at_max;
		logic rd_taken;
		logic bud_match;
		logic hd_is_target;
		logic walk_cont;
		logic prev_nil;
		logic sel_hi;
		logic out_free;
	} flags_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SEARCH,
		S_SP_RD,
		S_SP_WR,
		S_SP_BUD,
		S_SP_BLK,
		S_AL_RD,
		S_AL_WR,
		S_F_RD,
		S_F_CHK,
		S_F_PUSH,
		S_M_CHK,
		S_M_EVAL,
		S_RM_START,
		S_RM_WALK,
		S_RM_LINK,
		S_RM_POP_RD,
		S_RM_POP_WR,
		S_RM_DONE,
		S_M_PUSH,
		S_DONE
	} state_t;

endpackage

@@ sv/bpa_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Standalone; no package needed.
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/bpa_ctrl.sv @@
// Sequencing state machine of the buddy page allocator.
// Depends on bpa_pkg; drives bpa_dpath through cmd_t and reads flags_t.
module bpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  bpa_pkg::flags_t flags,
	output bpa_pkg::cmd_t   cmd,
	output logic            in_ready
);

	bpa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = bpa_pkg::OP_NONE;
		cmd.code = bpa_pkg::RES_OK;
		in_ready = 1'b0;
		unique case (state_q)
			bpa_pkg::S_CLEAR: begin
				cmd.op = bpa_pkg::OP_CLEAR;
				if (flags.clr_last) begin
					state_d = bpa_pkg::S_IDLE;
				end
			end
			bpa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = bpa_pkg::OP_ACCEPT;
					state_d = bpa_pkg::S_CHECK;
				end
			end
			bpa_pkg::S_CHECK: begin
				priority if (flags.is_free) begin
					state_d = bpa_pkg::S_F_RD;
				end else if (flags.ord_big) begin
					cmd.op   = bpa_pkg::OP_FINISH;
					cmd.code = bpa_pkg::RES_ORDER_BIG;
					state_d  = bpa_pkg::S_DONE;
				end else begin
					state_d = bpa_pkg::S_SEARCH;
				end
			end
			bpa_pkg::S_SEARCH: begin
				priority if (flags.lvl_gt_max) begin
					cmd.op   = bpa_pkg::OP_FINISH;
					cmd.code = bpa_pkg::RES_NO_BLOCK;
					state_d  = bpa_pkg::S_DONE;
				end else if (flags.head_nil) begin
					cmd.op = bpa_pkg::OP_LVL_INC;
				end else if (flags.lvl_eq_ord) begin
					state_d = bpa_pkg::S_AL_RD;
				end else begin
					state_d = bpa_pkg::S_SP_RD;
				end
			end
			bpa_pkg::S_SP_RD: begin
				if (flags.head_nil) begin
					cmd.op   = bpa_pkg::OP_FINISH;
					cmd.code = bpa_pkg::RES_NO_BLOCK;
					state_d  = bpa_pkg::S_DONE;
				end else begin
					cmd.op  = bpa_pkg::OP_POP_RD;
					state_d = bpa_pkg::S_SP_WR;
				end
			end
			bpa_pkg::S_SP_WR: begin
				cmd.op  = bpa_pkg::OP_SPLIT_POP;
				state_d = bpa_pkg::S_SP_BUD;
			end
			bpa_pkg::S_SP_BUD: begin
				cmd.op  = bpa_pkg::OP_PUSH_BUD;
				state_d = bpa_pkg::S_SP_BLK;
			end
			bpa_pkg::S_SP_BLK: begin
				cmd.op  = bpa_pkg::OP_PUSH_BLK;
				state_d = flags.lvl_eq_ord ? bpa_pkg::S_AL_RD : bpa_pkg::S_SP_RD;
			end
			bpa_pkg::S_AL_RD: begin
				if (flags.head_nil) begin
					cmd.op   = bpa_pkg::OP_FINISH;
					cmd.code = bpa_pkg::RES_NO_BLOCK;
					state_d  = bpa_pkg::S_DONE;
				end else begin
					cmd.op  = bpa_pkg::OP_POP_RD;
					state_d = bpa_pkg::S_AL_WR;
				end
			end
			bpa_pkg::S_AL_WR: begin
				cmd.op  = bpa_pkg::OP_POP_TAKE;
				state_d = bpa_pkg::S_DONE;
			end
			bpa_pkg::S_F_RD: begin
				cmd.op  = bpa_pkg::OP_META_RD;
				state_d = bpa_pkg::S_F_CHK;
			end
			bpa_pkg::S_F_CHK: begin
				if (!flags.rd_taken) begin
					cmd.op   = bpa_pkg::OP_FINISH;
					cmd.code = bpa_pkg::RES_DOUBLE_FREE;
					state_d  = bpa_pkg::S_DONE;
				end else begin
					cmd.op  = bpa_pkg::OP_FREE_SET;
					state_d = bpa_pkg::S_F_PUSH;
				end
			end
			bpa_pkg::S_F_PUSH: begin
				cmd.op  = bpa_pkg::OP_PUSH_BLK;
				state_d = bpa_pkg::S_M_CHK;
			end
			bpa_pkg::S_M_CHK: begin
				if (flags.lvl_at_max) begin
					state_d = bpa_pkg::S_DONE;
				end else begin
					cmd.op  = bpa_pkg::OP_BUD_RD;
					state_d = bpa_pkg::S_M_EVAL;
				end
			end
			bpa_pkg::S_M_EVAL: begin
				if (flags.bud_match) begin
					cmd.op  = bpa_pkg::OP_BUD_EVAL;
					state_d = bpa_pkg::S_RM_START;
				end else begin
					state_d = bpa_pkg::S_DONE;
				end
			end
			bpa_pkg::S_RM_START: begin
				priority if (flags.head_nil) begin
					state_d = bpa_pkg::S_RM_DONE;
				end else if (flags.hd_is_target) begin
					state_d = bpa_pkg::S_RM_POP_RD;
				end else begin
					cmd.op  = bpa_pkg::OP_RM_START;
					state_d = bpa_pkg::S_RM_WALK;
				end
			end
			bpa_pkg::S_RM_WALK: begin
				priority if (flags.walk_cont) begin
					cmd.op = bpa_pkg::OP_RM_STEP;
				end else if (flags.prev_nil) begin
					state_d = bpa_pkg::S_RM_DONE;
				end else begin
					cmd.op  = bpa_pkg::OP_RM_UNLINK;
					state_d = bpa_pkg::S_RM_LINK;
				end
			end
			bpa_pkg::S_RM_LINK: begin
				cmd.op  = bpa_pkg::OP_RM_LINK;
				state_d = bpa_pkg::S_RM_POP_RD;
			end
			bpa_pkg::S_RM_POP_RD: begin
				cmd.op  = bpa_pkg::OP_POP_RD;
				state_d = bpa_pkg::S_RM_POP_WR;
			end
			bpa_pkg::S_RM_POP_WR: begin
				cmd.op  = bpa_pkg::OP_POP_WR;
				state_d = bpa_pkg::S_RM_DONE;
			end
			bpa_pkg::S_RM_DONE: begin
				if (!flags.sel_hi) begin
					cmd.op  = bpa_pkg::OP_RM_NEXT;
					state_d = bpa_pkg::S_RM_START;
				end else begin
					cmd.op  = bpa_pkg::OP_LVL_INC;
					state_d = bpa_pkg::S_M_PUSH;
				end
			end
			bpa_pkg::S_M_PUSH: begin
				cmd.op  = bpa_pkg::OP_PUSH_BLK;
				state_d = bpa_pkg::S_M_CHK;
			end
			bpa_pkg::S_DONE: begin
				if (flags.out_free) begin
					cmd.op  = bpa_pkg::OP_OUT_LOAD;
					state_d = bpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpa_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ sv/bpa_dpath.sv @@
// Datapath of the buddy page allocator: list heads, link/order/taken RAMs,
// walk registers and the result register. Depends on bpa_pkg and bpa_ram.
module bpa_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bpa_pkg::cmd_t                    cmd,
	output bpa_pkg::flags_t                  flags,
	input  logic                             func,
	input  logic [bpa_pkg::ORDER_W-1:0]      order,
	input  logic [bpa_pkg::PAGE_IN_W-1:0]    page,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic [bpa_pkg::PAGE_IN_W-1:0]    page_out
);

	logic [bpa_pkg::LINK_W-1:0]  head_q [bpa_pkg::MAX_ORDER+1];
	logic                        func_q;
	logic [bpa_pkg::ORDER_W-1:0] ord_q;
	logic [bpa_pkg::PAGE_W-1:0]  page_q, blk_q, hi_q, target_q, hq_q, tail_q, clr_cnt_q;
	logic [bpa_pkg::LVL_W-1:0]   lvl_q;
	logic                        sel_hi_q;
	logic [bpa_pkg::LINK_W-1:0]  hd_q, prev_q;
	logic [bpa_pkg::STEP_W-1:0]  steps_q;
	bpa_pkg::res_code_t          res_status_q, out_status_q;
	logic [bpa_pkg::PAGE_W-1:0]  res_page_q;
	logic [bpa_pkg::PAGE_IN_W-1:0] out_page_q;
	logic                        out_valid_q;

	logic [bpa_pkg::LINK_W-1:0]  head_cur;
	logic [bpa_pkg::PAGE_W-1:0]  bud, lo, hi, rd_addr;
	logic                        nx_we, lv_we, tk_we;
	logic [bpa_pkg::PAGE_W-1:0]  nx_wa, lv_wa, tk_wa;
	logic [bpa_pkg::LINK_W-1:0]  nx_wd, nx_rd;
	logic [bpa_pkg::LVL_W-1:0]   lv_wd, lv_rd;
	logic                        tk_wd, tk_rd;
	logic                        is_push;
	logic [bpa_pkg::PAGE_W-1:0]  push_addr;

	assign head_cur = (lvl_q <= bpa_pkg::LVL_W'(bpa_pkg::MAX_ORDER))
		? head_q[lvl_q[bpa_pkg::HEAD_IDX_W-1:0]] : bpa_pkg::NIL;
	assign bud = blk_q ^ (bpa_pkg::PAGE_W'(1) << lvl_q);
	assign lo  = (blk_q < bud) ? blk_q : bud;
	assign hi  = (blk_q < bud) ? bud : blk_q;
	assign is_push   = (cmd.op == bpa_pkg::OP_PUSH_BUD) || (cmd.op == bpa_pkg::OP_PUSH_BLK);
	assign push_addr = (cmd.op == bpa_pkg::OP_PUSH_BUD) ? bud : blk_q;

	always_comb begin
		unique case (cmd.op)
			bpa_pkg::OP_POP_RD,
			bpa_pkg::OP_RM_START: rd_addr = head_cur[bpa_pkg::PAGE_W-1:0];
			bpa_pkg::OP_RM_STEP:  rd_addr = nx_rd[bpa_pkg::PAGE_W-1:0];
			bpa_pkg::OP_META_RD:  rd_addr = page_q;
			bpa_pkg::OP_BUD_RD:   rd_addr = bud;
			default:              rd_addr = blk_q;
		endcase
	end

	// RAM write ports.
	always_comb begin
		nx_we = 1'b0;
		nx_wa = hq_q;
		nx_wd = bpa_pkg::NIL;
		lv_we = 1'b0;
		lv_wa = push_addr;
		lv_wd = lvl_q;
		tk_we = 1'b0;
		tk_wa = hq_q;
		tk_wd = 1'b1;
		unique case (cmd.op)
			bpa_pkg::OP_CLEAR: begin
				nx_we = 1'b1;
				nx_wa = clr_cnt_q;
				lv_we = 1'b1;
				lv_wa = clr_cnt_q;
				lv_wd = '0;
				tk_we = 1'b1;
				tk_wa = clr_cnt_q;
			end
			bpa_pkg::OP_POP_WR, bpa_pkg::OP_POP_TAKE, bpa_pkg::OP_SPLIT_POP: begin
				nx_we = 1'b1;
				tk_we = 1'b1;
			end
			bpa_pkg::OP_PUSH_BUD, bpa_pkg::OP_PUSH_BLK: begin
				nx_we = 1'b1;
				nx_wa = push_addr;
				nx_wd = head_cur;
				lv_we = 1'b1;
				tk_we = 1'b1;
				tk_wa = push_addr;
				tk_wd = 1'b0;
			end
			bpa_pkg::OP_RM_UNLINK: begin
				nx_we = 1'b1;
				nx_wa = prev_q[bpa_pkg::PAGE_W-1:0];
			end
			bpa_pkg::OP_RM_LINK: begin
				nx_we = 1'b1;
				nx_wa = tail_q;
				nx_wd = hd_q;
			end
			default: begin
			end
		endcase
	end

	bpa_ram #(.WIDTH(bpa_pkg::LINK_W), .DEPTH(bpa_pkg::NPAGES)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(rd_addr), .rdata(nx_rd)
	);
	bpa_ram #(.WIDTH(bpa_pkg::LVL_W), .DEPTH(bpa_pkg::NPAGES)) u_level (
		.clk(clk), .we(lv_we), .waddr(lv_wa), .wdata(lv_wd), .raddr(rd_addr), .rdata(lv_rd)
	);
	bpa_ram #(.WIDTH(1), .DEPTH(bpa_pkg::NPAGES)) u_taken (
		.clk(clk), .we(tk_we), .waddr(tk_wa), .wdata(tk_wd), .raddr(rd_addr), .rdata(tk_rd)
	);

	// List heads are reset to empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= bpa_pkg::MAX_ORDER; i++) begin
				head_q[i] <= bpa_pkg::NIL;
			end
		end else begin
			if (cmd.op == bpa_pkg::OP_POP_WR || cmd.op == bpa_pkg::OP_POP_TAKE
					|| cmd.op == bpa_pkg::OP_SPLIT_POP) begin
				head_q[lvl_q[bpa_pkg::HEAD_IDX_W-1:0]] <= nx_rd;
			end else if (is_push) begin
				head_q[lvl_q[bpa_pkg::HEAD_IDX_W-1:0]] <= bpa_pkg::LINK_W'(push_addr);
			end else if (cmd.op == bpa_pkg::OP_RM_UNLINK) begin
				head_q[lvl_q[bpa_pkg::HEAD_IDX_W-1:0]] <= bpa_pkg::LINK_W'(target_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == bpa_pkg::OP_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + bpa_pkg::PAGE_W'(1);
			end
			if (cmd.op == bpa_pkg::OP_OUT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bpa_pkg::OP_ACCEPT: begin
				func_q       <= func;
				ord_q        <= order;
				page_q       <= bpa_pkg::PAGE_W'(page);
				lvl_q        <= bpa_pkg::LVL_W'(order);
				res_status_q <= bpa_pkg::RES_OK;
				res_page_q   <= '0;
			end
			bpa_pkg::OP_LVL_INC:   lvl_q <= lvl_q + bpa_pkg::LVL_W'(1);
			bpa_pkg::OP_POP_RD:    hq_q  <= head_cur[bpa_pkg::PAGE_W-1:0];
			bpa_pkg::OP_SPLIT_POP: begin
				blk_q <= hq_q;
				lvl_q <= lvl_q - bpa_pkg::LVL_W'(1);
			end
			bpa_pkg::OP_POP_TAKE:  res_page_q <= hq_q;
			bpa_pkg::OP_FREE_SET: begin
				blk_q <= page_q;
				lvl_q <= lv_rd;
			end
			bpa_pkg::OP_BUD_EVAL: begin
				blk_q    <= lo;
				target_q <= lo;
				hi_q     <= hi;
				sel_hi_q <= 1'b0;
			end
			bpa_pkg::OP_RM_START: begin
				hd_q    <= head_cur;
				tail_q  <= head_cur[bpa_pkg::PAGE_W-1:0];
				prev_q  <= bpa_pkg::NIL;
				steps_q <= '0;
			end
			bpa_pkg::OP_RM_STEP: begin
				if (nx_rd == bpa_pkg::LINK_W'(target_q)) begin
					prev_q <= bpa_pkg::LINK_W'(tail_q);
				end
				tail_q  <= nx_rd[bpa_pkg::PAGE_W-1:0];
				steps_q <= steps_q + bpa_pkg::STEP_W'(1);
			end
			bpa_pkg::OP_RM_NEXT: begin
				target_q <= hi_q;
				sel_hi_q <= 1'b1;
			end
			bpa_pkg::OP_FINISH:    res_status_q <= cmd.code;
			bpa_pkg::OP_OUT_LOAD: begin
				out_status_q <= res_status_q;
				out_page_q   <= bpa_pkg::PAGE_IN_W'(res_page_q);
			end
			default: begin
			end
		endcase
	end

	assign flags.clr_last     = (clr_cnt_q == bpa_pkg::PAGE_W'(bpa_pkg::NPAGES - 1));
	assign flags.is_free      = func_q;
	assign flags.ord_big      = (ord_q > bpa_pkg::ORDER_W'(bpa_pkg::MAX_ORDER));
	assign flags.lvl_gt_max   = (lvl_q > bpa_pkg::LVL_W'(bpa_pkg::MAX_ORDER));
	assign flags.head_nil     = (head_cur == bpa_pkg::NIL);
	assign flags.lvl_eq_ord   = (bpa_pkg::ORDER_W'(lvl_q) == ord_q);
	assign flags.lvl_at_max   = (lvl_q >= bpa_pkg::LVL_W'(bpa_pkg::MAX_ORDER));
	assign flags.rd_taken     = tk_rd;
	assign flags.bud_match    = (lv_rd == lvl_q) && !tk_rd;
	assign flags.hd_is_target = (head_cur == bpa_pkg::LINK_W'(target_q));
	assign flags.walk_cont    = (nx_rd != bpa_pkg::NIL)
		&& (steps_q < bpa_pkg::STEP_W'(bpa_pkg::NPAGES));
	assign flags.prev_nil     = (prev_q == bpa_pkg::NIL);
	assign flags.sel_hi       = sel_hi_q;
	assign flags.out_free     = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign page_out  = out_page_q;

endmodule

@@ sv/buddy_page_allocator.sv @@
// Top level of the buddy page allocator: ties the controller to the datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_dpath.
//
// The allocator manages 2^MAX_ORDER pages (1024) in one LIFO free list per
// order. An item with func clear allocates a block of 2^order pages and returns
// its first page; an item with func set frees the block starting at page and
// merges it with free buddies. Each item produces exactly one result item with
// a status (ok, order too large, no free block, double free) and page_out.
// After reset every page counts as taken, and the block first runs a clearing
// pass over its link, order and taken memories; in_ready stays low until it
// ends. The block works on one item at a time. An order that is too large is
// rejected after the check, and a double free after the taken bit is read. An
// allocate searches upward from the requested order and splits the block it
// finds down to that order; when no list can serve it, it ends after the
// search. A free returns the block to its list and then merges it with each
// free buddy in turn, up to the top order; a buddy that must be unlinked
// from the middle of its list is found by following the links to the end of
// the list, since the link memory returns one entry per cycle. A finished
// result sits in an output register, so the next item is accepted while the
// previous result waits; a second result waits in the controller until that
// register drains.
module buddy_page_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [bpa_pkg::ORDER_W-1:0]   order,
	input  logic [bpa_pkg::PAGE_IN_W-1:0] page,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [bpa_pkg::PAGE_IN_W-1:0] page_out
);

	bpa_pkg::cmd_t   cmd;
	bpa_pkg::flags_t flags;

	// The controller steps through the list operations; the datapath owns all
	// storage and reports the conditions the controller branches on.
	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.flags    (flags),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	bpa_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.flags     (flags),
		.func      (func),
		.order     (order),
		.page      (page),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.page_out  (page_out)
	);

endmodule
